// File: rtl/core/xcrc_pkg.sv
// Package for the XMODEM-CRC receiver: beat types, control byte codes, phase codes
// and the CRC-16 byte update function. No dependencies.
`default_nettype none
package xcrc_pkg;

    localparam int unsigned MAX_IMAGE_BYTES = 1048576;
    localparam int unsigned LEN_W = 21;
    localparam int unsigned ADDR_W = 20;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_RETRY   = 3'd2;
    localparam logic [2:0] ST_SEQ     = 3'd3;
    localparam logic [2:0] ST_OVF     = 3'd4;
    localparam logic [2:0] ST_CANCEL  = 3'd5;

    localparam logic [2:0] CFG_MAX_LEN = 3'd0;
    localparam logic [2:0] CFG_BYTE_TO = 3'd1;
    localparam logic [2:0] CFG_PKT_TO  = 3'd2;
    localparam logic [2:0] CFG_FLUSH   = 3'd3;
    localparam logic [2:0] CFG_RETRIES = 3'd4;
    localparam logic [2:0] CFG_TRIES   = 3'd5;

    typedef enum logic [8:0] {
        PH_IDLE  = 9'b000000001,
        PH_INIT  = 9'b000000010,
        PH_NUM   = 9'b000000100,
        PH_NUMC  = 9'b000001000,
        PH_DATA  = 9'b000010000,
        PH_CRCH  = 9'b000100000,
        PH_CRCL  = 9'b001000000,
        PH_HDR   = 9'b010000000,
        PH_FLUSH = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } in_beat_t;

    typedef struct packed {
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              done_res;
        logic [2:0]        status;
        logic [LEN_W-1:0]  length;
        logic              last;
    } out_beat_t;

    typedef struct packed {
        logic [LEN_W-1:0] max_length;
        logic [15:0]      byte_timeout_ticks;
        logic [15:0]      packet_timeout_ticks;
        logic [15:0]      flush_quiet_ticks;
        logic [7:0]       max_retries;
        logic [7:0]       init_try_limit;
    } cfg_t;

    // Results of one item: a write, or up to six transmit bytes with an optional end.
    typedef struct packed {
        logic [2:0]        n_tx;
        logic [7:0]        tx0;
        logic              abort;
        logic              wr_valid;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              done;
        logic [2:0]        status;
        logic [LEN_W-1:0]  length;
    } plan_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/xcrc_cfg.sv
// Configuration register file of the XMODEM-CRC receiver.
// Depends on xcrc_pkg.
`default_nettype none
module xcrc_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [20:0]      cfg_data,
    output xcrc_pkg::cfg_t        cfg
);
    import xcrc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length           <= LEN_W'(MAX_IMAGE_BYTES);
            cfg_reg.byte_timeout_ticks   <= 16'd1000;
            cfg_reg.packet_timeout_ticks <= 16'd3000;
            cfg_reg.flush_quiet_ticks    <= 16'd50;
            cfg_reg.max_retries          <= 8'd10;
            cfg_reg.init_try_limit       <= 8'd26;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LEN: cfg_reg.max_length <= cfg_data;
                CFG_BYTE_TO: cfg_reg.byte_timeout_ticks <= cfg_data[15:0];
                CFG_PKT_TO:  cfg_reg.packet_timeout_ticks <= cfg_data[15:0];
                CFG_FLUSH:   cfg_reg.flush_quiet_ticks <= cfg_data[15:0];
                CFG_RETRIES: cfg_reg.max_retries <= cfg_data[7:0];
                CFG_TRIES:   cfg_reg.init_try_limit <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

// File: rtl/core/xcrc_proto.sv
// Protocol engine of the XMODEM-CRC receiver: phase, counters and CRC check.
// Processes one registered item per cycle and produces a result plan. Depends on xcrc_pkg.
`default_nettype none
module xcrc_proto (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  xcrc_pkg::cfg_t         cfg,
    input  wire logic              item_valid,
    input  xcrc_pkg::in_beat_t     item,
    output xcrc_pkg::plan_t        plan
);
    import xcrc_pkg::*;

    phase_t       phase_reg, phase_next;
    logic         first_reg, first_next;
    logic         large_reg, large_next;
    logic [7:0]   blk_reg, blk_next;
    logic [9:0]   idx_reg, idx_next;
    logic [15:0]  crc_reg, crc_next;
    logic [7:0]   crch_reg, crch_next;
    logic [15:0]  tick_reg, tick_next;
    logic [LEN_W-1:0] clen_reg, clen_next;
    logic [7:0]   expn_reg, expn_next;
    logic [7:0]   nak_reg, nak_next;
    logic [1:0]   can_reg, can_next;
    logic [7:0]   try_reg, try_next;
    logic         fct_reg, fct_next;

    logic [LEN_W-1:0] lim;
    logic [LEN_W-1:0] size;
    logic [LEN_W-1:0] addr;
    logic [LEN_W:0]   sum;
    logic [15:0]      tick_inc;
    logic [7:0]       b;
    logic [7:0]       try_inc;
    logic [7:0]       nak_inc;
    logic [1:0]       can_inc;

    assign lim = (cfg.max_length > LEN_W'(MAX_IMAGE_BYTES)) ? LEN_W'(MAX_IMAGE_BYTES)
                                                            : cfg.max_length;
    assign size = large_reg ? LEN_W'(1024) : LEN_W'(128);
    assign addr = clen_reg + LEN_W'(idx_reg);
    assign sum = {1'b0, clen_reg} + {1'b0, size};
    assign tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign b = item.rx_byte;
    assign try_inc = (try_reg == 8'hFF) ? try_reg : try_reg + 8'd1;
    assign nak_inc = (nak_reg == 8'hFF) ? nak_reg : nak_reg + 8'd1;
    assign can_inc = (can_reg == 2'd3) ? can_reg : can_reg + 2'd1;

    always_comb
    begin
        phase_next = phase_reg; first_next = first_reg; large_next = large_reg;
        blk_next = blk_reg; idx_next = idx_reg; crc_next = crc_reg; crch_next = crch_reg;
        tick_next = tick_reg; clen_next = clen_reg; expn_next = expn_reg;
        nak_next = nak_reg; can_next = can_reg; try_next = try_reg; fct_next = fct_reg;
        plan = '0;
        if (item_valid)
        begin
            if (item.kind == KIND_START)
            begin
                first_next = 1'b1; large_next = 1'b0; blk_next = '0; idx_next = '0;
                crc_next = '0; crch_next = '0; clen_next = '0; expn_next = 8'd1;
                nak_next = '0; can_next = '0; try_next = '0; fct_next = 1'b0;
                tick_next = '0;
                if (cfg.init_try_limit == 8'd0)
                begin
                    phase_next = PH_IDLE; plan.done = 1'b1; plan.status = ST_TIMEOUT;
                end
                else
                begin
                    phase_next = PH_INIT; plan.n_tx = 3'd1; plan.tx0 = CH_C;
                end
            end
            else if (item.kind == KIND_BYTE)
            begin
                unique case (phase_reg)
                    PH_INIT:
                    begin
                        if (b == CH_SOH || b == CH_STX)
                        begin
                            large_next = (b == CH_STX); phase_next = PH_NUM; tick_next = '0;
                        end
                        else if (b == CH_CAN)
                        begin
                            can_next = can_inc;
                            if (can_inc >= 2'd2)
                            begin
                                phase_next = PH_IDLE; plan.done = 1'b1;
                                plan.status = ST_CANCEL;
                            end
                        end
                        else
                        begin
                            can_next = '0; try_next = try_inc;
                            if (try_inc >= cfg.init_try_limit)
                            begin
                                phase_next = PH_IDLE; plan.done = 1'b1;
                                plan.status = ST_TIMEOUT;
                            end
                            else
                            begin
                                plan.n_tx = 3'd1; plan.tx0 = CH_C; tick_next = '0;
                            end
                        end
                    end
                    PH_NUM:
                    begin
                        blk_next = b; phase_next = PH_NUMC; tick_next = '0;
                    end
                    PH_NUMC:
                    begin
                        tick_next = '0;
                        if ((blk_reg ^ b) != 8'hFF)
                        begin
                            fct_next = 1'b0; phase_next = PH_FLUSH;
                        end
                        else
                        begin
                            phase_next = PH_DATA; idx_next = '0; crc_next = '0;
                        end
                    end
                    PH_DATA:
                    begin
                        tick_next = '0;
                        if (addr < lim)
                        begin
                            plan.wr_valid = 1'b1; plan.wr_addr = addr[ADDR_W-1:0];
                            plan.wr_data = b;
                        end
                        crc_next = crc_update(crc_reg, b);
                        if (LEN_W'(idx_reg) + LEN_W'(1) >= size)
                        begin
                            idx_next = '0; phase_next = PH_CRCH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 10'd1;
                        end
                    end
                    PH_CRCH:
                    begin
                        tick_next = '0; crch_next = b; phase_next = PH_CRCL;
                    end
                    PH_CRCL:
                    begin
                        tick_next = '0;
                        if ({crch_reg, b} != crc_reg)
                        begin
                            fct_next = 1'b0; phase_next = PH_FLUSH;
                        end
                        else if (first_reg)
                        begin
                            if (blk_reg != 8'd1)
                            begin
                                plan.abort = 1'b1; plan.done = 1'b1; plan.status = ST_SEQ;
                                phase_next = PH_IDLE;
                            end
                            else if (size > lim)
                            begin
                                plan.abort = 1'b1; plan.done = 1'b1; plan.status = ST_OVF;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                clen_next = size; expn_next = 8'd2; first_next = 1'b0;
                                nak_next = '0; plan.n_tx = 3'd1; plan.tx0 = CH_ACK;
                                phase_next = PH_HDR;
                            end
                        end
                        else if (blk_reg == expn_reg - 8'd1)
                        begin
                            plan.n_tx = 3'd1; plan.tx0 = CH_ACK; phase_next = PH_HDR;
                        end
                        else if (blk_reg != expn_reg)
                        begin
                            plan.abort = 1'b1; plan.done = 1'b1; plan.status = ST_SEQ;
                            phase_next = PH_IDLE;
                        end
                        else if (sum > {1'b0, lim})
                        begin
                            plan.abort = 1'b1; plan.done = 1'b1; plan.status = ST_OVF;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            clen_next = sum[LEN_W-1:0]; expn_next = expn_reg + 8'd1;
                            nak_next = '0; plan.n_tx = 3'd1; plan.tx0 = CH_ACK;
                            phase_next = PH_HDR;
                        end
                    end
                    PH_HDR:
                    begin
                        if (b == CH_EOT)
                        begin
                            plan.n_tx = 3'd1; plan.tx0 = CH_ACK; plan.done = 1'b1;
                            plan.status = ST_OK; plan.length = clen_reg;
                            phase_next = PH_IDLE;
                        end
                        else if (b == CH_CAN)
                        begin
                            can_next = can_inc;
                            if (can_inc >= 2'd2)
                            begin
                                phase_next = PH_IDLE; plan.done = 1'b1;
                                plan.status = ST_CANCEL;
                            end
                            else
                            begin
                                tick_next = '0;
                            end
                        end
                        else
                        begin
                            can_next = '0; tick_next = '0;
                            if (b == CH_SOH || b == CH_STX)
                            begin
                                large_next = (b == CH_STX); phase_next = PH_NUM;
                            end
                            else
                            begin
                                fct_next = 1'b0; phase_next = PH_FLUSH;
                            end
                        end
                    end
                    PH_FLUSH: tick_next = '0;
                    default: ;
                endcase
            end
            else if (item.kind == KIND_TICK && phase_reg != PH_IDLE)
            begin
                tick_next = tick_inc;
                unique case (phase_reg)
                    PH_INIT:
                    begin
                        if (tick_inc >= cfg.packet_timeout_ticks)
                        begin
                            can_next = '0; try_next = try_inc;
                            if (try_inc >= cfg.init_try_limit)
                            begin
                                phase_next = PH_IDLE; plan.done = 1'b1;
                                plan.status = ST_TIMEOUT;
                            end
                            else
                            begin
                                plan.n_tx = 3'd1; plan.tx0 = CH_C; tick_next = '0;
                            end
                        end
                    end
                    PH_HDR:
                    begin
                        if (tick_inc >= cfg.packet_timeout_ticks)
                        begin
                            can_next = '0; fct_next = 1'b1; phase_next = PH_FLUSH;
                            tick_next = '0;
                        end
                    end
                    PH_FLUSH:
                    begin
                        if (tick_inc >= cfg.flush_quiet_ticks)
                        begin
                            nak_next = nak_inc; plan.tx0 = CH_NAK; tick_next = '0;
                            if (nak_inc >= cfg.max_retries)
                            begin
                                plan.n_tx = 3'd1; plan.abort = 1'b1; plan.done = 1'b1;
                                plan.status = (!first_reg && fct_reg) ? ST_TIMEOUT : ST_RETRY;
                                phase_next = PH_IDLE;
                            end
                            else if (first_reg)
                            begin
                                try_next = try_inc;
                                if (try_inc >= cfg.init_try_limit)
                                begin
                                    plan.n_tx = 3'd1; plan.done = 1'b1;
                                    plan.status = ST_TIMEOUT; phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    plan.n_tx = 3'd2; phase_next = PH_INIT;
                                end
                            end
                            else
                            begin
                                plan.n_tx = 3'd1; phase_next = PH_HDR;
                            end
                        end
                    end
                    default:
                    begin
                        if (tick_inc >= cfg.byte_timeout_ticks)
                        begin
                            fct_next = 1'b1; phase_next = PH_FLUSH; tick_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; first_reg <= 1'b1; large_reg <= 1'b0; blk_reg <= '0;
            idx_reg <= '0; crc_reg <= '0; crch_reg <= '0; tick_reg <= '0; clen_reg <= '0;
            expn_reg <= 8'd1; nak_reg <= '0; can_reg <= '0; try_reg <= '0; fct_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; first_reg <= first_next; large_reg <= large_next;
            blk_reg <= blk_next; idx_reg <= idx_next; crc_reg <= crc_next;
            crch_reg <= crch_next; tick_reg <= tick_next; clen_reg <= clen_next;
            expn_reg <= expn_next; nak_reg <= nak_next; can_reg <= can_next;
            try_reg <= try_next; fct_reg <= fct_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/xcrc_emit.sv
// Result sequencer of the XMODEM-CRC receiver: holds result plans in a small queue and
// sends their beats one at a time on the output channel. Depends on xcrc_pkg.
`default_nettype none
module xcrc_emit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            plan_valid,
    input  xcrc_pkg::plan_t      plan,
    output logic                 space_ok,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output xcrc_pkg::out_beat_t  out_data
);
    import xcrc_pkg::*;

    localparam int unsigned DEPTH = 4;

    plan_t      q_mem [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic [2:0] sub_reg;
    plan_t      head;
    logic [2:0] total;
    logic       is_last;
    logic       pop;
    logic       take;

    assign head = q_mem[rp_reg];
    assign total = head.abort ? 3'd6
                 : ((head.n_tx == 3'd0) ? 3'd1 : head.n_tx);
    assign is_last = (sub_reg == total - 3'd1);
    assign out_valid = (cnt_reg != 3'd0);
    assign take = out_valid && !out_stall;
    assign pop = take && is_last;
    assign space_ok = (cnt_reg < 3'd3) || (cnt_reg == 3'd3 && pop);

    always_comb
    begin
        out_data = '0;
        out_data.last = is_last;
        if (head.abort)
        begin
            out_data.tx_valid = 1'b1;
            if (head.n_tx == 3'd1)
            begin
                // A retry abort sends its NAK ahead of the cancel sequence.
                out_data.tx_byte = (sub_reg == 3'd0) ? CH_NAK
                                 : ((sub_reg < 3'd4) ? CH_CAN : CH_BS);
            end
            else
            begin
                out_data.tx_byte = (sub_reg < 3'd3) ? CH_CAN : CH_BS;
            end
        end
        else if (head.n_tx == 3'd2)
        begin
            out_data.tx_valid = 1'b1;
            out_data.tx_byte = (sub_reg == 3'd0) ? CH_NAK : CH_C;
        end
        else if (head.n_tx == 3'd1)
        begin
            out_data.tx_valid = 1'b1; out_data.tx_byte = head.tx0;
        end
        else if (head.wr_valid)
        begin
            out_data.wr_valid = 1'b1; out_data.wr_addr = head.wr_addr;
            out_data.wr_data = head.wr_data;
        end
        if (is_last && head.done)
        begin
            out_data.done_res = 1'b1; out_data.status = head.status;
            out_data.length = head.length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_valid)
        begin
            q_mem[wp_reg] <= plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; sub_reg <= '0;
        end
        else
        begin
            if (plan_valid)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1; sub_reg <= '0;
            end
            else if (take)
            begin
                sub_reg <= sub_reg + 3'd1;
            end
            cnt_reg <= cnt_reg + 3'(plan_valid) - 3'(pop);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/xmodem_crc_receiver_top.sv
// Top level of the XMODEM-CRC/1K receiver: configuration registers, protocol engine
// and result sequencer. Depends on xcrc_pkg, xcrc_cfg, xcrc_proto and xcrc_emit.
// An item is taken into an input register and processed in the next cycle, so one item
// can be accepted every cycle while in_stall is low. Each item yields zero to six result
// beats; the output sequencer sends one beat a cycle, while out_stall is low, from a
// four-entry plan queue, so the sustained rate is set by the output port.
`default_nettype none
module xmodem_crc_receiver_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  xcrc_pkg::in_beat_t       in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output xcrc_pkg::out_beat_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [20:0]         cfg_data
);
    import xcrc_pkg::*;

    cfg_t     cfg;
    in_beat_t item_reg;
    logic     item_valid_reg;
    plan_t    plan;
    logic     space_ok;
    logic     plan_valid;

    xcrc_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    xcrc_proto u_proto (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .item_valid(item_valid_reg),
        .item(item_reg), .plan(plan)
    );

    assign plan_valid = item_valid_reg && (plan.n_tx != 3'd0 || plan.abort
                        || plan.wr_valid || plan.done);

    xcrc_emit u_emit (
        .clk(clk), .rst_n(rst_n), .plan_valid(plan_valid), .plan(plan),
        .space_ok(space_ok), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    // The queue must hold the item in flight as well as the new one.
    assign in_stall = !space_ok || (item_valid_reg && !space_ok);

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= in_valid && !in_stall;
        end
    end
endmodule
`default_nettype wire
